[rtl/core/sla_pkg.sv]
// Shared types and constants for the serial line assembler.
`timescale 1ns / 1ps
`default_nettype none
package sla_pkg;

    localparam int MAX_LINE_DEF = 32;
    localparam int RESULT_CAP   = 32;
    localparam int CNT_W        = $clog2(RESULT_CAP + 1);
    localparam int Q_DEPTH      = 2;
    localparam int QAW          = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic OP_RX   = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_LINE = 2'd1;
    localparam logic [1:0] STATUS_OVF  = 2'd2;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
        logic [7:0] read_capacity;
    } req_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] line_byte;
        logic       byte_valid;
        logic       last;
    } rsp_item_t;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_TERM,
        CMD_READ,
        CMD_READ_ZERO
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
        logic [7:0] cap;
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_STREAM
    } back_state_t;

endpackage
`default_nettype wire

[rtl/core/sla_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

[rtl/core/sla_front.sv]
// Front end: classifies request transfers and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module sla_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire sla_pkg::req_item_t req,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output sla_pkg::cmd_t          cmd
);
    import sla_pkg::*;

    cmd_t               q_reg [Q_DEPTH];
    logic [QAW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]       count_reg, count_next;
    cmd_t               cls;
    logic               push, pop;

    always_comb
    begin
        cls.data = req.rx_byte;
        cls.cap  = req.read_capacity;
        if (req.opcode == OP_READ)
        begin
            cls.kind = (req.read_capacity == 8'd0) ? CMD_READ_ZERO : CMD_READ;
        end
        else
        begin
            cls.kind = (req.rx_byte == CH_CR || req.rx_byte == CH_LF) ? CMD_TERM : CMD_DATA;
        end
    end

    assign req_ready = (count_reg != (QAW+1)'(Q_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? QAW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QAW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/sla_back.sv]
// Back end: line state, line store, read streaming and response register.
`timescale 1ns / 1ps
`default_nettype none
module sla_back #(
    parameter int MAX_LINE = sla_pkg::MAX_LINE_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire sla_pkg::cmd_t     cmd,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output sla_pkg::rsp_item_t     rsp
);
    import sla_pkg::*;

    localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int LW = $clog2(MAX_LINE + 1);

    back_state_t        state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic               rdy_reg, rdy_next;
    logic               ovf_reg, ovf_next;
    logic               disc_reg, disc_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   issue_reg, issue_next;
    logic [CNT_W-1:0]   emit_reg, emit_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    rsp_item_t          out_reg, out_next;

    logic               can_load, cmd_fire, is_rx, go_stream, load_char, stream_done;
    logic [7:0]         cap_m1, len8, nmin;
    logic [CNT_W-1:0]   n_calc;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [7:0]         ram_rdata;

    sla_ram #(
        .WIDTH(8),
        .DEPTH(MAX_LINE)
    ) u_store (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(cmd.data),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign can_load  = !out_valid_reg || rsp_ready;
    assign is_rx     = (cmd.kind == CMD_DATA) || (cmd.kind == CMD_TERM);
    assign cmd_ready = (state_reg == BK_IDLE) && (is_rx || can_load);
    assign cmd_fire  = cmd_valid && cmd_ready;

    // delivered count: min(length, capacity - 1, RESULT_CAP)
    always_comb
    begin
        cap_m1 = cmd.cap - 8'd1;
        len8   = 8'(len_reg);
        nmin   = (len8 < cap_m1) ? len8 : cap_m1;
        n_calc = (nmin > 8'(RESULT_CAP)) ? CNT_W'(RESULT_CAP) : CNT_W'(nmin);
    end

    assign go_stream   = cmd_fire && (cmd.kind == CMD_READ) && !ovf_reg && rdy_reg
                         && (n_calc != '0);
    assign load_char   = (state_reg == BK_STREAM) && pend_reg && can_load;
    assign stream_done = load_char && (emit_reg + CNT_W'(1) == n_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (go_stream)
                begin
                    state_next = BK_STREAM;
                end
            end
            BK_STREAM:
            begin
                if (stream_done)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = AW'(len_reg);
        ram_re     = 1'b0;
        ram_raddr  = AW'(issue_reg);
        len_next   = len_reg;
        rdy_next   = rdy_reg;
        ovf_next   = ovf_reg;
        disc_next  = disc_reg;
        n_next     = n_reg;
        issue_next = issue_reg;
        emit_next  = emit_reg;
        pend_next  = pend_reg;
        out_next   = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_fire)
                begin
                    unique case (cmd.kind)
                        CMD_DATA:
                        begin
                            if (!rdy_reg && !ovf_reg && !disc_reg)
                            begin
                                if (len_reg < LW'(MAX_LINE))
                                begin
                                    ram_we   = 1'b1;
                                    len_next = len_reg + 1'b1;
                                end
                                else
                                begin
                                    len_next  = '0;
                                    disc_next = 1'b1;
                                end
                            end
                        end
                        CMD_TERM:
                        begin
                            if (!rdy_reg && !ovf_reg)
                            begin
                                if (disc_reg)
                                begin
                                    disc_next = 1'b0;
                                    ovf_next  = 1'b1;
                                end
                                else if (len_reg != '0)
                                begin
                                    rdy_next = 1'b1;
                                end
                            end
                        end
                        CMD_READ_ZERO:
                        begin
                            out_valid_next = 1'b1;
                            out_next = '{status: STATUS_NONE, line_byte: 8'd0,
                                         byte_valid: 1'b0, last: 1'b1};
                        end
                        CMD_READ:
                        begin
                            priority if (ovf_reg)
                            begin
                                ovf_next       = 1'b0;
                                out_valid_next = 1'b1;
                                out_next = '{status: STATUS_OVF, line_byte: 8'd0,
                                             byte_valid: 1'b0, last: 1'b1};
                            end
                            else if (!rdy_reg)
                            begin
                                out_valid_next = 1'b1;
                                out_next = '{status: STATUS_NONE, line_byte: 8'd0,
                                             byte_valid: 1'b0, last: 1'b1};
                            end
                            else
                            begin
                                len_next = '0;
                                rdy_next = 1'b0;
                                if (n_calc == '0)
                                begin
                                    out_valid_next = 1'b1;
                                    out_next = '{status: STATUS_LINE, line_byte: 8'd0,
                                                 byte_valid: 1'b0, last: 1'b1};
                                end
                                else
                                begin
                                    n_next     = n_calc;
                                    issue_next = '0;
                                    emit_next  = '0;
                                    pend_next  = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            BK_STREAM:
            begin
                // prefetch next character while the current one moves to the output
                ram_re = (issue_reg < n_reg) && (!pend_reg || can_load);
                if (ram_re)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                pend_next = ram_re || (pend_reg && !load_char);
                if (load_char)
                begin
                    emit_next      = emit_reg + 1'b1;
                    out_valid_next = 1'b1;
                    out_next = '{status: STATUS_LINE, line_byte: ram_rdata,
                                 byte_valid: 1'b1, last: stream_done};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            len_reg       <= '0;
            rdy_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            disc_reg      <= 1'b0;
            n_reg         <= '0;
            issue_reg     <= '0;
            emit_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            rdy_reg       <= rdy_next;
            ovf_reg       <= ovf_next;
            disc_reg      <= disc_next;
            n_reg         <= n_next;
            issue_reg     <= issue_next;
            emit_reg      <= emit_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule
`default_nettype wire

[rtl/core/serial_line_assembler.sv]
// Top level of the serial line assembler.
// Request channel (req_valid/req_ready/req): opcode 0 transfers one received
// byte, opcode 1 asks for the pending line with the caller's capacity.
// Response channel (rsp_valid/rsp_ready/rsp): one transfer per delivered
// character, or a single status transfer; the final one carries last.
// A two-entry command queue sits between the front end and the back end.
// Received bytes retire one per cycle while no line streams. A status-only answer
// passes the queue and response register; a line's first character also passes
// the stream start and line store read, then characters follow one per cycle while
// rsp_ready holds, paced by the registered read port of the line store.
// When the receiver stalls, the response register holds its transfer, reads
// and a streaming line wait, the queue fills and req_ready drops.
// Reset empties the queue and the line and clears the ready, overflow and
// discard flags; the line store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module serial_line_assembler #(
    parameter int MAX_LINE = sla_pkg::MAX_LINE_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_ready,
    input  wire sla_pkg::req_item_t req,
    output logic                    rsp_valid,
    input  wire logic               rsp_ready,
    output sla_pkg::rsp_item_t      rsp
);
    import sla_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    sla_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd)
    );

    sla_back #(
        .MAX_LINE(MAX_LINE)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

endmodule
`default_nettype wire
